/* design/running_min_max_mean_std_unit_assert.svh */
// ----------------------------------------------------------------------------
// Running statistics unit: assertion macros
// Shared property forms for the concurrent checks of the statistics unit.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MIN_MAX_MEAN_STD_UNIT_ASSERT_SVH
`define RUNNING_MIN_MAX_MEAN_STD_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RMMS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define RMMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rmms_pkg.sv */
// ----------------------------------------------------------------------------
// rmms_pkg
// Types and constants shared by the running statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmms_pkg;

   // field widths
   localparam int SAMPLE_BITS  = 16;
   localparam int COUNT_BITS   = 20;
   localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
   localparam int SQSUM_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PROD_BITS    = 2 * SAMPLE_BITS;
   localparam int ROOT_BITS    = SAMPLE_BITS;
   localparam int DIV_CNT_BITS = $clog2(SQSUM_BITS);

   // command queue between front and back (depth is a power of two)
   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_LVL_BITS = CMD_PTR_BITS + 1;

   // input command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REPORT = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // classified operation carried to the back end
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REPORT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] min_value;
      logic signed [SAMPLE_BITS-1:0] max_value;
      logic signed [SAMPLE_BITS-1:0] mean_value;
      logic [SAMPLE_BITS-1:0]        std_value;
      logic [COUNT_BITS-1:0]         sample_count;
      logic                          overflow;
   } rsp_type;

   typedef struct packed {
      op_type                        op;
      logic signed [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic                    full;
      logic                    empty;
      logic [CMD_LVL_BITS-1:0] level;
   } fifo_stat_type;

   typedef struct packed {
      logic busy;
      logic rsp_load;
   } back_stat_type;

endpackage

`default_nettype wire

/* design/rmms_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// rmms_cmd_fifo
// Short first-word-fall-through queue of classified operations.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_cmd_fifo import rmms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  item_type      push_data,
   input  logic          pop,
   output item_type      pop_data,
   output fifo_stat_type stat
);

   localparam logic [CMD_LVL_BITS-1:0] FULL_LEVEL = CMD_LVL_BITS'(CMD_DEPTH);

   item_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_LVL_BITS-1:0] level_ff, level_in;
   logic                    push_ok, pop_ok;

   // status and head entry
   assign stat.full  = (level_ff == FULL_LEVEL);
   assign stat.empty = (level_ff == '0);
   assign stat.level = level_ff;
   assign pop_data   = mem_ff[rd_ptr_ff];

   assign push_ok = push && !stat.full;
   assign pop_ok  = pop && !stat.empty;

   // pointer and level update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push_ok, pop_ok})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/rmms_front.sv */
// ----------------------------------------------------------------------------
// rmms_front
// Input stage: takes transactions, decodes the command, drops unused codes
// and hands operations to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_front import rmms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  req_type       req_data,
   output logic          full,
   input  fifo_stat_type fifo_stat,
   output logic          item_push,
   output item_type      item_data
);

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_ff, stage_in;
   item_type decoded;
   logic     keep;
   logic     accept;

   // command decode; the unused code is accepted and dropped
   always_comb begin
      decoded.sample = req_data.sample;
      decoded.op     = OP_ADD;
      keep           = 1'b1;
      unique case (req_data.command)
         CMD_ADD:    decoded.op = OP_ADD;
         CMD_REPORT: decoded.op = OP_REPORT;
         CMD_CLEAR:  decoded.op = OP_CLEAR;
         default:    keep = 1'b0;
      endcase
   end

   // handshake: stage drains into the queue whenever it has room
   assign item_push = stage_valid_ff && !fifo_stat.full;
   assign full      = stage_valid_ff && fifo_stat.full;
   assign accept    = push && !full;
   assign item_data = stage_ff;

   always_comb begin
      stage_valid_in = (stage_valid_ff && !item_push) || (accept && keep);
      stage_in       = accept ? decoded : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

/* design/rmms_div.sv */
// ----------------------------------------------------------------------------
// rmms_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_div import rmms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SQSUM_BITS-1:0] dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [SQSUM_BITS-1:0] quotient
);

   localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(SQSUM_BITS - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] step_ff, step_in;
   logic [SQSUM_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   dsr_ff, dsr_in;
   logic [COUNT_BITS:0]     shifted;
   logic [COUNT_BITS:0]     diff;
   logic                    fits;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[SQSUM_BITS-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SQSUM_BITS-2:0], fits};
         rem_in  = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* design/rmms_sqrt.sv */
// ----------------------------------------------------------------------------
// rmms_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_sqrt import rmms_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] radicand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   // highest power of four within the radicand width
   localparam logic [PROD_BITS-1:0] BIT_TOP = {2'b01, {(PROD_BITS-2){1'b0}}};

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [PROD_BITS-1:0] rem_ff, rem_in;
   logic [PROD_BITS-1:0] res_ff, res_in;
   logic [PROD_BITS-1:0] bit_ff, bit_in;
   logic [PROD_BITS-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = BIT_TOP;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last step uses the lowest bit
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];

endmodule

`default_nettype wire

/* design/rmms_back.sv */
// ----------------------------------------------------------------------------
// rmms_back
// Execution side: accumulates samples, clears, runs for a nonempty report the
// mean and mean-square divisions and the root, and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_back import rmms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  fifo_stat_type fifo_stat,
   input  item_type      item_data,
   output logic          item_pop,
   input  logic          pop,
   output logic          empty,
   output rsp_type       rsp_data,
   output back_stat_type stat
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MEAN   = 6'b000010,
      ST_EX2    = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_EMIT   = 6'b100000
   } back_state_type;

   back_state_type                state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SQSUM_BITS-1:0]         sqsum_ff, sqsum_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [SAMPLE_BITS-1:0]        std_ff, std_in;
   logic                          ovf_ff, ovf_in;
   logic [PROD_BITS-1:0]          sq_ff, sq_in;
   logic                          sq_valid_ff, sq_valid_in;
   logic [SAMPLE_BITS-1:0]        mean_mag_ff, mean_mag_in;
   logic [PROD_BITS-1:0]          ex2_ff, ex2_in;
   logic [PROD_BITS-1:0]          m2_ff, m2_in;
   rsp_type                       rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [PROD_BITS-1:0]   prod;
   logic [SUM_BITS-1:0]           sum_mag;
   logic [PROD_BITS-1:0]          variance;
   logic                          count_full;
   logic                          rsp_load;
   logic                          div_start, div_done;
   logic [SQSUM_BITS-1:0]         div_dividend;
   logic [SQSUM_BITS-1:0]         div_quo;
   logic                          sqrt_start, sqrt_done;
   logic [ROOT_BITS-1:0]          sqrt_root;

   rmms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   rmms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (variance),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // datapath helpers
   assign prod       = PROD_BITS'(item_data.sample) * PROD_BITS'(item_data.sample);
   assign sum_mag    = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign variance   = (ex2_ff > m2_ff) ? ex2_ff - m2_ff : '0;
   assign count_full = &count_ff;
   assign item_pop   = (state_ff == ST_IDLE) && !fifo_stat.empty;

   // control and accumulation
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      mean_in      = mean_ff;
      std_in       = std_ff;
      ovf_in       = ovf_ff;
      sq_in        = sq_ff;
      sq_valid_in  = 1'b0;
      mean_mag_in  = mean_mag_ff;
      ex2_in       = ex2_ff;
      m2_in        = m2_ff;
      div_start    = 1'b0;
      div_dividend = {{(SQSUM_BITS-SUM_BITS){1'b0}}, sum_mag};
      sqrt_start   = 1'b0;
      rsp_load     = 1'b0;

      // second add stage: fold last square into the sum of squares
      if (sq_valid_ff) begin
         sqsum_in = sqsum_ff + {{(SQSUM_BITS-PROD_BITS){1'b0}}, sq_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_pop) begin
               unique case (item_data.op)
                  OP_ADD: begin
                     if (count_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        if (count_ff == '0) begin
                           min_in = item_data.sample;
                           max_in = item_data.sample;
                        end else begin
                           if (item_data.sample < min_ff) min_in = item_data.sample;
                           if (item_data.sample > max_ff) max_in = item_data.sample;
                        end
                        count_in    = count_ff + 1'b1;
                        sum_in      = sum_ff + SUM_BITS'(item_data.sample);
                        sq_in       = PROD_BITS'(unsigned'(prod));
                        sq_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     min_in   = '0;
                     max_in   = '0;
                     count_in = '0;
                     sum_in   = '0;
                     sqsum_in = '0;
                     mean_in  = '0;
                     std_in   = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_REPORT: begin
                     if (count_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = ST_MEAN;
                     end else begin
                        state_in  = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               mean_in      = sum_ff[SUM_BITS-1] ? -div_quo[SAMPLE_BITS-1:0]
                                                 :  div_quo[SAMPLE_BITS-1:0];
               mean_mag_in  = div_quo[SAMPLE_BITS-1:0];
               div_start    = 1'b1;
               div_dividend = sqsum_ff;
               state_in     = ST_EX2;
            end
         end
         ST_EX2: begin
            if (div_done) begin
               ex2_in   = div_quo[PROD_BITS-1:0];
               m2_in    = PROD_BITS'(mean_mag_ff) * PROD_BITS'(mean_mag_ff);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               std_in   = sqrt_root;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.min_value    = min_ff;
         rsp_in.max_value    = max_ff;
         rsp_in.mean_value   = mean_ff;
         rsp_in.std_value    = std_ff;
         rsp_in.sample_count = count_ff;
         rsp_in.overflow     = ovf_ff;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '0;
         max_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         mean_ff      <= '0;
         std_ff       <= '0;
         ovf_ff       <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         mean_ff      <= mean_in;
         std_ff       <= std_in;
         ovf_ff       <= ovf_in;
         sq_valid_ff  <= sq_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      mean_mag_ff <= mean_mag_in;
      ex2_ff      <= ex2_in;
      m2_ff       <= m2_in;
      rsp_ff      <= rsp_in;
   end

   assign empty         = !rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.busy     = (state_ff != ST_IDLE);
   assign stat.rsp_load = rsp_load;

endmodule

`default_nettype wire

/* design/running_min_max_mean_std_unit.sv */
// ----------------------------------------------------------------------------
// running_min_max_mean_std_unit
// Running min, max, count, mean and population standard deviation over
// signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Add and clear transactions retire one per cycle: the front stage and a
// four-entry command queue take a new transaction every cycle while the back
// end keeps up, and each add passes through a two-stage accumulator (square
// then sum of squares). A report with samples runs in the back end through
// the shared one-bit-per-cycle divider (52 steps for the mean, 52 for the
// mean square) and the 16-step square root; a report with no samples goes
// straight to the result register. While a report is computed the queue
// keeps accepting until it fills. The single result register lets the back
// end continue with adds while a report waits to be popped. No clearing
// pass follows reset.
`default_nettype none

`include "running_min_max_mean_std_unit_assert.svh"

module running_min_max_mean_std_unit import rmms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   fifo_stat_type fifo_stat;
   back_stat_type back_stat;
   logic          item_push;
   item_type      item_data;
   logic          cmd_pop;
   item_type      cmd_data;

   rmms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .fifo_stat (fifo_stat),
      .item_push (item_push),
      .item_data (item_data)
   );

   rmms_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .stat      (fifo_stat)
   );

   rmms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_stat (fifo_stat),
      .item_data (cmd_data),
      .item_pop  (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .stat      (back_stat)
   );

   // checks
   `RMMS_ASSERT_IMPLY(a_busy_no_pop, back_stat.busy, !cmd_pop, "command taken while back end busy")
   `RMMS_ASSERT_IMPLY(a_no_push_full, fifo_stat.full, !item_push, "push into full command queue")
   `RMMS_ASSERT_IMPLY(a_load_free, back_stat.rsp_load, empty || pop, "waiting result overwritten")
   `RMMS_ASSERT_NEXT(a_load_shows, back_stat.rsp_load, !empty, "loaded result not presented")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: running statistics unit testbench
// Drives add, report, clear and unused-code transactions into the unit,
// tracks min, max, count, sums, mean and standard deviation alongside it, and
// checks every report field by field. Runs directed corner cases, random
// add runs under several idle and stall mixes, and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import rmms_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_ITEMS  = 275;
   localparam int MAX_ERR_LINES = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // transaction queues
   req_type pending_reqs[$];
   rsp_type expected_reports[$];

   // tracked statistics
   logic signed [SAMPLE_BITS-1:0] st_min, st_max, st_mean;
   logic [SAMPLE_BITS-1:0]        st_std;
   logic [COUNT_BITS-1:0]         st_count;
   longint                        st_sum;
   longint unsigned               st_sqsum;
   logic                          st_overflow;

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int reports_sent = 0;
   bit hold_go = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   running_min_max_mean_std_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // one line per mismatch, printing capped
   task automatic report_error(input string msg);
      if (error_count < MAX_ERR_LINES)
         $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // fold one accepted transaction into the statistics, queue a report
   task automatic apply_command(input req_type r);
      logic signed [SAMPLE_BITS-1:0] s;
      longint sv, mean_full;
      longint unsigned cnt, ex2, am, m2, var_v, rem, root, bitv;
      rsp_type rpt;
      case (r.command)
         CMD_ADD: begin
            s = r.sample;
            if (st_count == '1) begin
               st_overflow = 1'b1;
            end else begin
               if (st_count == 0) begin
                  st_min = s;
                  st_max = s;
               end else begin
                  if (s < st_min) st_min = s;
                  if (s > st_max) st_max = s;
               end
               st_count = st_count + 1'b1;
               sv = s;
               st_sum = st_sum + sv;
               st_sqsum = st_sqsum + longint'(sv * sv);
            end
         end
         CMD_CLEAR: begin
            st_min = '0; st_max = '0; st_count = '0; st_sum = 0; st_sqsum = 0;
            st_mean = '0; st_std = '0; st_overflow = 1'b0;
         end
         CMD_REPORT: begin
            if (st_count != 0) begin
               cnt = st_count;
               mean_full = st_sum / longint'(cnt);
               ex2 = st_sqsum / cnt;
               am = (mean_full < 0) ? -mean_full : mean_full;
               m2 = am * am;
               var_v = (ex2 > m2) ? ex2 - m2 : 0;
               // floor square root, two bits per step
               rem = var_v;
               root = 0;
               bitv = 64'd1 << 62;
               while (bitv > rem) bitv = bitv >> 2;
               while (bitv != 0) begin
                  if (rem >= root + bitv) begin
                     rem = rem - (root + bitv);
                     root = (root >> 1) + bitv;
                  end else begin
                     root = root >> 1;
                  end
                  bitv = bitv >> 2;
               end
               st_mean = mean_full[SAMPLE_BITS-1:0];
               st_std = root[SAMPLE_BITS-1:0];
            end
            rpt.min_value = st_min;
            rpt.max_value = st_max;
            rpt.mean_value = st_mean;
            rpt.std_value = st_std;
            rpt.sample_count = st_count;
            rpt.overflow = st_overflow;
            expected_reports.push_back(rpt);
         end
         default: ; // unused code: no effect
      endcase
   endtask

   // driver: present the next pending transaction, hold it until taken
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) apply_command(req_data);
         if (!push || !full) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor: check each popped report against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_reports.size() == 0) begin
               report_error("report with no expectation pending");
            end else begin
               want = expected_reports.pop_front();
               check_field("min_value", 32'(rsp_data.min_value), 32'(want.min_value));
               check_field("max_value", 32'(rsp_data.max_value), 32'(want.max_value));
               check_field("mean_value", 32'(rsp_data.mean_value),
                           32'(want.mean_value));
               check_field("std_value", 32'(rsp_data.std_value), 32'(want.std_value));
               check_field("sample_count", 32'(rsp_data.sample_count),
                           32'(want.sample_count));
               check_field("overflow", 32'(rsp_data.overflow), 32'(want.overflow));
            end
         end
         // long hold-off once, otherwise random stalls
         if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(input logic [1:0] cmd, input logic [SAMPLE_BITS-1:0] smp);
      req_type r;
      r.command = cmd;
      r.sample = smp;
      while (pending_reqs.size() >= 16) @(posedge clock);
      pending_reqs.push_back(r);
      if (cmd == CMD_REPORT) reports_sent++;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || push || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      int mode;
      mode = $urandom_range(9);
      if (mode == 0) begin
         case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
         endcase
      end else if (mode <= 3) begin
         return 16'($urandom_range(512) - 256);
      end
      return 16'($urandom_range(65535));
   endfunction

   initial begin
      int ph, phase_items, run_len, pick;
      st_min = '0; st_max = '0; st_count = '0; st_sum = 0; st_sqsum = 0;
      st_mean = '0; st_std = '0; st_overflow = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_cmd(CMD_REPORT, 16'h0000);          // report with no samples
      send_cmd(CMD_UNUSED, 16'h5555);          // ignored code
      send_cmd(CMD_ADD, 16'h7fff);
      send_cmd(CMD_ADD, 16'h8000);
      send_cmd(CMD_REPORT, 16'h0000);
      send_cmd(CMD_ADD, 16'h0000);
      send_cmd(CMD_ADD, 16'hffff);
      send_cmd(CMD_ADD, 16'h0001);
      send_cmd(CMD_REPORT, 16'hffff);
      send_cmd(CMD_CLEAR, 16'h1234);
      send_cmd(CMD_REPORT, 16'h0000);          // empty after clear
      repeat (3) send_cmd(CMD_ADD, -16'sd300); // equal samples, zero variance
      send_cmd(CMD_REPORT, 16'h0000);
      send_cmd(CMD_CLEAR, 16'h0000);
      repeat (2) send_cmd(CMD_ADD, 16'h8000);
      send_cmd(CMD_REPORT, 16'h0000);
      send_cmd(CMD_UNUSED, 16'haaaa);
      send_cmd(CMD_CLEAR, 16'hffff);
      send_cmd(CMD_ADD, 16'd100);
      send_cmd(CMD_ADD, -16'sd7);
      send_cmd(CMD_REPORT, 16'h0000);
      send_cmd(CMD_CLEAR, 16'h0000);
      wait_drained();

      // random phases: none, sender idle, receiver stall, both
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 27 : 0;
         recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 27 : 0;
         phase_items = 0;
         if (ph == 0) begin
            // hold results back while reports and adds keep coming
            hold_go = 1'b1;
            repeat (6) begin
               send_cmd(CMD_REPORT, random_sample());
               repeat (8) send_cmd(CMD_ADD, random_sample());
            end
            phase_items += 54;
         end
         while (phase_items < PHASE_ITEMS || (ph == 3 && reports_sent < 60)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_cmd(CMD_CLEAR, random_sample());
               phase_items++;
            end else if (pick < 7) begin
               send_cmd(CMD_UNUSED, random_sample());
            end else if (pick < 10) begin
               send_cmd(CMD_REPORT, random_sample());
               phase_items++;
            end else begin
               run_len = $urandom_range(40, 1);
               repeat (run_len) send_cmd(CMD_ADD, random_sample());
               send_cmd(CMD_REPORT, random_sample());
               phase_items += run_len + 1;
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
